@@ design/windowed_snr_quality_gate_core_macros.svh @@
// Assertion macros shared by the windowed SNR quality gate modules.
`ifndef WINDOWED_SNR_QUALITY_GATE_CORE_MACROS_SVH
`define WINDOWED_SNR_QUALITY_GATE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define WSQG_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define WSQG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/wsqg_pkg.sv @@
// Package with shared constants, codes and types of the windowed SNR quality gate.
package wsqg_pkg;

  // Default sizes of the sample and index fields.
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int INDEX_BITS_DEF  = 16;

  // Fixed widths of the energy sums, the ratio and the configuration port.
  localparam int ENERGY_W   = 64;
  localparam int RATIO_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STATUS_W   = 2;

  // Iteration counter, wide enough for the 32 quotient bits and the index bits.
  localparam int CNT_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO    = 3'd4;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic load_mul;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic sat;
  } sts_t;

endpackage

@@ design/wsqg_in_if.sv @@
// Input channel interface: one trace sample per transaction.
interface wsqg_in_if
  import wsqg_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

@@ design/wsqg_out_if.sv @@
// Output channel interface: one ratio result per transaction.
interface wsqg_out_if
  import wsqg_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [RATIO_W-1:0]  ratio;
  logic                passed;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output ratio, output passed, output status, input ready);
  modport sink   (input valid, input ratio, input passed, input status, output ready);
endinterface

@@ design/wsqg_ctrl.sv @@
// Controller state machine: sequences accumulation, multiply, divide and result hand-off.
`include "windowed_snr_quality_gate_core_macros.svh"

module wsqg_ctrl
  import wsqg_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_RUN   = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(INDEX_BITS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(RATIO_W - 1);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             take;
  logic             out_free;

  // Samples are taken only while a trace is streaming in.
  assign in_ready_o  = (state_q == S_RUN);
  assign take        = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state, iteration counter and commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.take = take;
    case (state_q)
      S_RUN: begin
        if (take && in_last_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load_mul = 1'b1;
        cnt_d          = MUL_LAST;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_CHK;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_CHK: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = DIV_LAST;
        state_d        = sts_i.sat ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  // Output register valid: set on load, cleared when the transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `WSQG_ASSERT_NEXT(a_last_stops_input, (take && in_last_i), (!in_ready_o), "input taken after last sample")
  `WSQG_ASSERT_NEXT(a_load_sets_valid, (cmd_o.load_out), (out_valid_q), "result load did not raise valid")
  `WSQG_ASSERT_NEXT(a_div_ends, (state_q == S_DIV && cnt_q == '0), (state_q == S_DONE), "division did not end after 32 steps")

endmodule

@@ design/wsqg_dp.sv @@
// Datapath: window energy accumulation, shift-add multiplier and restoring divider.
`include "windowed_snr_quality_gate_core_macros.svh"

module wsqg_dp
  import wsqg_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output sts_t                          sts_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  output logic [RATIO_W-1:0]            ratio_o,
  output logic                          passed_o,
  output logic [STATUS_W-1:0]           status_o
);

  localparam int CW = INDEX_BITS + 1;            // sample counter
  localparam int PW = ENERGY_W + INDEX_BITS;     // energy times window length
  localparam int RW = PW + FRAC_BITS;            // dividend and remainder
  localparam int DW = PW + RATIO_W;              // shifted divisor

  // Configuration registers.
  logic [INDEX_BITS-1:0] noise_start_q, noise_end_q, signal_start_q, signal_end_q;
  logic [RATIO_W-1:0]    min_ratio_q;

  // Trace state.
  logic [CW-1:0]       idx_q, idx_inc, len_q;
  logic [ENERGY_W-1:0] noise_e_q, signal_e_q;

  // Sample pipeline.
  logic [SAMPLE_BITS-1:0]   raw, mag_d, mag_q;
  logic [2*SAMPLE_BITS-1:0] sq_full;
  logic [ENERGY_W-1:0]      sq_q;
  logic                     va_q, vb_q;
  logic                     nhit_d, shit_d, nhita_q, shita_q, nhitb_q, shitb_q;

  // Multiplier and divider.
  logic [PW-1:0]         mc_sig_q, mc_noi_q, acc_num_q, acc_den_q;
  logic [INDEX_BITS-1:0] mp_n_q, mp_s_q;
  logic [RW-1:0]         num_sh, rem_q;
  logic [DW-1:0]         den_sh, dv_q;
  logic                  sat_c, sat_q, ge;
  logic [RATIO_W-1:0]    quo_q;

  // Result.
  status_e            st;
  logic [RATIO_W-1:0] ratio_c;
  logic [RATIO_W-1:0] ratio_q;
  logic               passed_q;
  status_e            status_q;

  function automatic logic [ENERGY_W-1:0] sat_add(input logic [ENERGY_W-1:0] a,
                                                  input logic [ENERGY_W-1:0] b);
    logic [ENERGY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ENERGY_W] ? '1 : s[ENERGY_W-1:0];
  endfunction

  // Configuration writes; window registers keep their low index bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_start_q  <= '0;
      noise_end_q    <= '0;
      signal_start_q <= '0;
      signal_end_q   <= '0;
      min_ratio_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NOISE_START:  noise_start_q  <= cfg_data_i[INDEX_BITS-1:0];
        REG_NOISE_END:    noise_end_q    <= cfg_data_i[INDEX_BITS-1:0];
        REG_SIGNAL_START: signal_start_q <= cfg_data_i[INDEX_BITS-1:0];
        REG_SIGNAL_END:   signal_end_q   <= cfg_data_i[INDEX_BITS-1:0];
        REG_MIN_RATIO:    min_ratio_q    <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage A: sample magnitude and window membership of the current index.
  assign raw     = sample_i;
  assign mag_d   = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  assign idx_inc = (idx_q == '1) ? idx_q : (idx_q + 1'b1);
  assign nhit_d  = (idx_q >= {1'b0, noise_start_q}) && (idx_q < {1'b0, noise_end_q});
  assign shit_d  = (idx_q >= {1'b0, signal_start_q}) && (idx_q < {1'b0, signal_end_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      va_q  <= 1'b0;
    end else begin
      va_q <= cmd_i.take;
      if (cmd_i.take) begin
        idx_q <= last_i ? '0 : idx_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mag_q   <= mag_d;
      nhita_q <= nhit_d;
      shita_q <= shit_d;
      if (last_i) begin
        len_q <= idx_inc;
      end
    end
  end

  // Stage B: square of the magnitude.
  assign sq_full = mag_q * mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (va_q) begin
      sq_q    <= ENERGY_W'(sq_full);
      nhitb_q <= nhita_q;
      shitb_q <= shita_q;
    end
  end

  // Stage C: saturating energy sums, cleared once copied to the multiplier.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_e_q  <= '0;
      signal_e_q <= '0;
    end else if (cmd_i.load_mul) begin
      noise_e_q  <= '0;
      signal_e_q <= '0;
    end else if (vb_q) begin
      if (nhitb_q) begin
        noise_e_q <= sat_add(noise_e_q, sq_q);
      end
      if (shitb_q) begin
        signal_e_q <= sat_add(signal_e_q, sq_q);
      end
    end
  end

  assign sts_o.pipe_busy = va_q || vb_q;

  // Shift-add multiply: signal energy by noise length, noise energy by signal length.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mul) begin
      mc_sig_q  <= PW'(signal_e_q);
      mc_noi_q  <= PW'(noise_e_q);
      mp_n_q    <= noise_end_q - noise_start_q;
      mp_s_q    <= signal_end_q - signal_start_q;
      acc_num_q <= '0;
      acc_den_q <= '0;
    end else if (cmd_i.mul_step) begin
      acc_num_q <= acc_num_q + (mp_n_q[0] ? mc_sig_q : '0);
      acc_den_q <= acc_den_q + (mp_s_q[0] ? mc_noi_q : '0);
      mc_sig_q  <= mc_sig_q << 1;
      mc_noi_q  <= mc_noi_q << 1;
      mp_n_q    <= mp_n_q >> 1;
      mp_s_q    <= mp_s_q >> 1;
    end
  end

  // Saturation check: the quotient needs more than 32 bits, or the noise is zero.
  assign num_sh    = {acc_num_q, {FRAC_BITS{1'b0}}};
  assign den_sh    = {acc_den_q, {RATIO_W{1'b0}}};
  assign sat_c     = (DW'(num_sh) >= den_sh);
  assign sts_o.sat = sat_c;

  // Restoring division, one quotient bit per step from the top.
  assign ge = (DW'(rem_q) >= dv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= num_sh;
      dv_q  <= den_sh >> 1;
      sat_q <= sat_c;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dv_q[RW-1:0];
      end
      quo_q <= {quo_q[RATIO_W-2:0], ge};
      dv_q  <= dv_q >> 1;
    end
  end

  // Window checks against the trace length, then the result fields.
  always_comb begin
    if (({1'b0, noise_start_q} >= len_q) || ({1'b0, noise_end_q} >= len_q) ||
        ({1'b0, signal_start_q} >= len_q) || ({1'b0, signal_end_q} >= len_q)) begin
      st = ST_RANGE;
    end else if ((noise_end_q <= noise_start_q) || (signal_end_q <= signal_start_q)) begin
      st = ST_EMPTY;
    end else begin
      st = ST_OK;
    end
  end

  assign ratio_c = (st != ST_OK) ? '0 : (sat_q ? '1 : quo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ratio_q  <= ratio_c;
      passed_q <= (st == ST_OK) && (ratio_c >= min_ratio_q);
      status_q <= st;
    end
  end

  assign ratio_o  = ratio_q;
  assign passed_o = passed_q;
  assign status_o = status_q;

  `WSQG_ASSERT_NOW(a_rem_bound, (cmd_i.div_step), (({1'b0, rem_q}) < ({dv_q, 1'b0})), "remainder outside divisor bound")
  `WSQG_ASSERT_NOW(a_load_after_drain, (cmd_i.load_mul), (!va_q && !vb_q), "energies copied while samples in flight")

endmodule

@@ design/windowed_snr_quality_gate_core.sv @@
// Top level of the windowed SNR quality gate: controller, datapath and channel wiring.
// Within a trace one sample is taken per cycle; the square-and-sum pipeline is three deep.
// After the last sample come the pipeline drain, a one-bit-per-cycle multiply and a 32-step
// divide; the divide is skipped when the ratio saturates.
// The next trace starts once the result is loaded; the result waits there while it streams in.
// Reset clears configuration, sample counter, energy sums and all valid flags.
module windowed_snr_quality_gate_core
  import wsqg_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wsqg_in_if.sink               in_if,
  wsqg_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each trace and the result transaction.
  wsqg_ctrl #(
    .INDEX_BITS (INDEX_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_last_i   (in_if.last),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Accumulation, ratio arithmetic and result registers.
  wsqg_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (in_if.sample),
    .last_i     (in_if.last),
    .ratio_o    (out_if.ratio),
    .passed_o   (out_if.passed),
    .status_o   (out_if.status)
  );

endmodule
